// ===== src/twsa_pkg.sv =====
// Package for the temporary window slot allocator.
// Holds the sizing constants, codes, state type and bitmap helper functions.
// No dependencies.
package twsa_pkg;

    localparam int SLOTS        = 512;
    localparam int ROW_W        = 64;
    localparam int ROWS         = SLOTS / ROW_W;
    localparam int ROW_AW       = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int POS_W        = 6;
    localparam int SLOT_W       = 9;
    localparam int NF_W         = 10;
    localparam int RESERVED     = SLOTS - 1;
    localparam int RES_ROW      = RESERVED / ROW_W;
    localparam int RES_POS      = RESERVED % ROW_W;

    localparam logic [63:0] WIN_BASE = 64'hffff_ffff_ffe0_0000;

    localparam logic KIND_ALLOC   = 1'b0;
    localparam logic KIND_RELEASE = 1'b1;

    localparam logic [1:0] STATUS_OK   = 2'd0;
    localparam logic [1:0] STATUS_FULL = 2'd1;
    localparam logic [1:0] STATUS_BAD  = 2'd2;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_ALLOC,
        ST_SCAN,
        ST_REL
    } t_state;

    function automatic logic [ROW_W-1:0] reserved_mask(input logic [ROW_AW-1:0] row);
        logic [ROW_W-1:0] m;
        m = '0;
        if (row == ROW_AW'(RES_ROW)) begin
            m[RES_POS] = 1'b1;
        end
        return m;
    endfunction

    function automatic logic [POS_W-1:0] lowest_one(input logic [ROW_W-1:0] v);
        logic [ROW_W-1:0] iso;
        logic [POS_W-1:0] idx;
        iso = v & (~v + ROW_W'(1));
        idx = '0;
        for (int i = 0; i < ROW_W; i++) begin
            if (iso[i]) begin
                idx = idx | POS_W'(i);
            end
        end
        return idx;
    endfunction

endpackage

// ===== src/temp_window_slot_allocator.sv =====
// Temporary window slot allocator: present bits of the slots live in a
// bitmap RAM (one row of 64 slots per word), read, modified and written back.
// A full or bad request strobes its result in the cycle after accept.
// Busy: release is busy in ST_REL; allocate is busy in ST_ALLOC and ST_SCAN while the
// free-slot scan walks one bitmap row per cycle (1 to ROWS = 8); results never stall.
// Reset: synchronous; a clearing pass over all ROWS (8) rows zeroes the bitmap, busy high.
module temp_window_slot_allocator (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        i_kind,
    input  logic [51:0] i_frame_address,
    input  logic        i_allow_write,
    input  logic        i_allow_user,
    input  logic        i_allow_execute,
    input  logic [63:0] i_release_address,
    output logic        o_valid,
    output logic [63:0] o_window_address,
    output logic [63:0] o_entry_word,
    output logic        o_invalidate,
    output logic [1:0]  o_status
);
    import twsa_pkg::*;

    t_state               r_state, n_state;
    logic [ROW_AW-1:0]    r_row, n_row;
    logic [NF_W-1:0]      r_next_free, n_next_free;
    logic [SLOT_W-1:0]    r_slot, n_slot;
    logic [63:0]          r_word, n_word;
    logic                 r_valid, n_valid;
    logic [63:0]          r_waddr, n_waddr;
    logic [63:0]          r_entry, n_entry;
    logic                 r_inval, n_inval;
    logic [1:0]           r_status, n_status;

    logic                 ram_we;
    logic [ROW_AW-1:0]    ram_waddr;
    logic [ROW_W-1:0]     ram_wdata;
    logic [ROW_AW-1:0]    ram_raddr;
    logic [ROW_W-1:0]     ram_rdata;

    logic                 accept;
    logic                 is_full;
    logic [SLOT_W-1:0]    rel_slot;
    logic                 rel_bad;
    logic                 req_err;
    logic [POS_W-1:0]     slot_pos;
    logic [ROW_W-1:0]     slot_bit;
    logic [ROW_W-1:0]     row_set;
    logic [ROW_W-1:0]     above;
    logic [ROW_W-1:0]     free_vec;
    logic                 scan_hit;
    logic                 last_row;
    logic [NF_W-1:0]      hit_slot;

    twsa_ram #(
        .WIDTH(ROW_W),
        .DEPTH(ROWS)
    ) u_bitmap (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign busy     = (r_state != ST_IDLE);
    assign accept   = start && !busy;
    assign is_full  = (r_next_free >= NF_W'(SLOTS));
    assign rel_slot = i_release_address[20:12];
    assign rel_bad  = (i_release_address[63:21] != '1) || (rel_slot >= SLOT_W'(RESERVED));
    assign req_err  = (i_kind == KIND_ALLOC) ? is_full : rel_bad;

    assign slot_pos = r_slot[POS_W-1:0];
    assign slot_bit = ROW_W'(1) << slot_pos;
    assign row_set  = ram_rdata | slot_bit;
    assign above    = ({ROW_W{1'b1}} << slot_pos) << 1;
    assign free_vec = ((r_state == ST_ALLOC) ? (~row_set & above) : ~ram_rdata)
                      & ~reserved_mask(r_row);
    assign scan_hit = (free_vec != '0);
    assign last_row = (r_row == ROW_AW'(ROWS - 1));
    assign hit_slot = (NF_W'(r_row) << POS_W) | NF_W'(lowest_one(free_vec));

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_CLEAR: begin
                if (last_row) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (accept && !req_err) begin
                    n_state = (i_kind == KIND_ALLOC) ? ST_ALLOC : ST_REL;
                end
            end
            ST_ALLOC, ST_SCAN: begin
                if (scan_hit || last_row) begin
                    n_state = ST_IDLE;
                end else begin
                    n_state = ST_SCAN;
                end
            end
            ST_REL: begin
                n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        n_row       = r_row;
        n_next_free = r_next_free;
        n_slot      = r_slot;
        n_word      = r_word;
        n_valid     = 1'b0;
        n_waddr     = '0;
        n_entry     = '0;
        n_inval     = 1'b0;
        n_status    = STATUS_OK;
        ram_we      = 1'b0;
        ram_waddr   = r_row;
        ram_wdata   = '0;
        ram_raddr   = r_row;
        unique case (r_state)
            ST_CLEAR: begin
                ram_we = 1'b1;
                n_row  = r_row + ROW_AW'(1);
            end
            ST_IDLE: begin
                if (accept) begin
                    if (req_err) begin
                        n_valid  = 1'b1;
                        n_status = (i_kind == KIND_ALLOC) ? STATUS_FULL : STATUS_BAD;
                    end else if (i_kind == KIND_ALLOC) begin
                        n_slot    = r_next_free[SLOT_W-1:0];
                        n_row     = r_next_free[POS_W +: ROW_AW];
                        ram_raddr = r_next_free[POS_W +: ROW_AW];
                        n_word    = {~i_allow_execute, 11'b0, i_frame_address[51:12], 9'b0,
                                     i_allow_user, i_allow_write, 1'b1};
                    end else begin
                        n_slot    = rel_slot;
                        n_row     = rel_slot[POS_W +: ROW_AW];
                        ram_raddr = rel_slot[POS_W +: ROW_AW];
                    end
                end
            end
            ST_ALLOC, ST_SCAN: begin
                if (r_state == ST_ALLOC) begin
                    n_valid   = 1'b1;
                    n_waddr   = WIN_BASE | {43'b0, r_slot, 12'b0};
                    n_entry   = r_word;
                    ram_we    = 1'b1;
                    ram_wdata = row_set;
                end
                if (scan_hit) begin
                    n_next_free = hit_slot;
                end else if (last_row) begin
                    n_next_free = NF_W'(SLOTS);
                end else begin
                    n_row     = r_row + ROW_AW'(1);
                    ram_raddr = r_row + ROW_AW'(1);
                end
            end
            ST_REL: begin
                n_valid   = 1'b1;
                n_inval   = 1'b1;
                ram_we    = 1'b1;
                ram_wdata = ram_rdata & ~slot_bit;
                if (NF_W'(r_slot) < r_next_free) begin
                    n_next_free = NF_W'(r_slot);
                end
            end
            default: begin
                n_valid = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_row       <= '0;
            r_next_free <= '0;
            r_valid     <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_row       <= n_row;
            r_next_free <= n_next_free;
            r_valid     <= n_valid;
        end
        r_slot   <= n_slot;
        r_word   <= n_word;
        r_waddr  <= n_waddr;
        r_entry  <= n_entry;
        r_inval  <= n_inval;
        r_status <= n_status;
    end

    assign o_valid          = r_valid;
    assign o_window_address = r_waddr;
    assign o_entry_word     = r_entry;
    assign o_invalidate     = r_inval;
    assign o_status         = r_status;

endmodule

// ===== src/twsa_ram.sv =====
// Generic simple dual-port RAM with one write port and a registered read port.
// No dependencies.
module twsa_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 8
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

// ===== sim/tb_top.sv =====
// Testbench for the temporary window slot allocator: drives allocate and release
// transactions, predicts every result from a shadow copy of the window and checks it.
// Depends on twsa_pkg and temp_window_slot_allocator.
module tb_top;
    import twsa_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int MAX_PRINTS     = 200;

    typedef struct packed {
        logic        pause;
        logic        kind;
        logic [51:0] frame;
        logic        wr;
        logic        usr;
        logic        exe;
        logic [63:0] raddr;
    } t_window_req;

    typedef struct packed {
        logic [63:0] waddr;
        logic [63:0] word;
        logic        inval;
        logic [1:0]  status;
    } t_window_rsp;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    logic        i_kind;
    logic [51:0] i_frame_address;
    logic        i_allow_write;
    logic        i_allow_user;
    logic        i_allow_execute;
    logic [63:0] i_release_address;
    logic        o_valid;
    logic [63:0] o_window_address;
    logic [63:0] o_entry_word;
    logic        o_invalidate;
    logic [1:0]  o_status;

    t_window_req pending_q[$];
    t_window_rsp expected_q[$];
    t_window_req cur_req;
    logic [63:0] window_pte [SLOTS] = '{default: '0};
    logic [9:0]  lowest_free = '0;
    int          n_sent = 0;
    int          n_done = 0;
    int          n_err = 0;
    int          quiet_cycles = 0;
    logic        pause_next;

    temp_window_slot_allocator uut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .start             (start),
        .busy              (busy),
        .i_kind            (i_kind),
        .i_frame_address   (i_frame_address),
        .i_allow_write     (i_allow_write),
        .i_allow_user      (i_allow_user),
        .i_allow_execute   (i_allow_execute),
        .i_release_address (i_release_address),
        .o_valid           (o_valid),
        .o_window_address  (o_window_address),
        .o_entry_word      (o_entry_word),
        .o_invalidate      (o_invalidate),
        .o_status          (o_status)
    );

    always #1 i_clk = ~i_clk;

    function automatic t_window_rsp predict_window(t_window_req rq);
        t_window_rsp r;
        logic [8:0]  s;
        r = '0;
        if (rq.kind == KIND_ALLOC) begin
            if (lowest_free >= SLOTS) begin
                r.status = STATUS_FULL;
            end else begin
                s = lowest_free[8:0];
                r.word = {~rq.exe, 11'b0, rq.frame[51:12], 9'b0, rq.usr, rq.wr, 1'b1};
                r.waddr = WIN_BASE + (64'(s) << 12);
                window_pte[s] = r.word;
                do begin
                    lowest_free = lowest_free + 10'd1;
                    if (lowest_free == RESERVED) begin
                        lowest_free = lowest_free + 10'd1;
                    end
                end while (lowest_free < SLOTS && window_pte[lowest_free[8:0]][0]);
            end
        end else begin
            s = rq.raddr[20:12];
            if (rq.raddr < WIN_BASE || s >= RESERVED) begin
                r.status = STATUS_BAD;
            end else begin
                window_pte[s] = '0;
                r.inval = 1'b1;
                if (10'(s) < lowest_free) begin
                    lowest_free = 10'(s);
                end
            end
        end
        return r;
    endfunction

    task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
        if (n_err < MAX_PRINTS) begin
            $display("mismatch at result %0d: %s got %h want %h", n_done, what, got, want);
        end
        n_err++;
    endtask

    task automatic add_alloc(input logic [51:0] frame, input logic wr, input logic usr,
                             input logic exe);
        t_window_req rq;
        rq = '0;
        rq.pause = pause_next;
        rq.kind = KIND_ALLOC;
        rq.frame = frame;
        rq.wr = wr;
        rq.usr = usr;
        rq.exe = exe;
        rq.raddr = {$urandom, $urandom};
        pause_next = 1'b0;
        pending_q.push_back(rq);
    endtask

    task automatic add_release(input logic [63:0] addr);
        t_window_req rq;
        rq = '0;
        rq.pause = pause_next;
        rq.kind = KIND_RELEASE;
        rq.frame = 52'({$urandom, $urandom});
        rq.wr = 1'($urandom_range(0, 1));
        rq.usr = 1'($urandom_range(0, 1));
        rq.exe = 1'($urandom_range(0, 1));
        rq.raddr = addr;
        pause_next = 1'b0;
        pending_q.push_back(rq);
    endtask

    task automatic add_random_alloc();
        add_alloc(52'({$urandom, $urandom}), 1'($urandom_range(0, 1)),
                  1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
    endtask

    function automatic logic [63:0] slot_addr(input int s);
        return WIN_BASE | (64'(s) << 12) | 64'($urandom_range(0, 4095));
    endfunction

    task automatic add_noise();
        case ($urandom_range(0, 3))
            0: add_release({$urandom, $urandom});
            1: add_release(slot_addr(RESERVED));
            2: add_release(WIN_BASE - 64'd1 - 64'($urandom_range(0, 65535)));
            default: add_release({$urandom, $urandom} & ~(64'd1 << $urandom_range(21, 63)));
        endcase
    endtask

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
            i_kind <= KIND_ALLOC;
            i_frame_address <= '0;
            i_allow_write <= 1'b0;
            i_allow_user <= 1'b0;
            i_allow_execute <= 1'b0;
            i_release_address <= '0;
        end else begin
            if (start && !busy) begin
                expected_q.push_back(predict_window(cur_req));
                n_sent++;
            end
            if (start && busy) begin
                start <= 1'b1;
            end else if (pending_q.size() > 0
                         && !(pending_q[0].pause && n_sent != n_done)
                         && !(($urandom_range(0, 99) < 13) && !(n_sent >= 300 && n_sent < 480)))
            begin
                cur_req = pending_q.pop_front();
                start <= 1'b1;
                i_kind <= cur_req.kind;
                i_frame_address <= cur_req.frame;
                i_allow_write <= cur_req.wr;
                i_allow_user <= cur_req.usr;
                i_allow_execute <= cur_req.exe;
                i_release_address <= cur_req.raddr;
            end else begin
                start <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_window_rsp e;
        if (i_rst_n && o_valid) begin
            if (expected_q.size() == 0) begin
                report("unexpected result, window address", o_window_address, '0);
            end else begin
                e = expected_q.pop_front();
                if (o_window_address !== e.waddr) begin
                    report("window address", o_window_address, e.waddr);
                end
                if (o_entry_word !== e.word) begin
                    report("entry word", o_entry_word, e.word);
                end
                if (o_invalidate !== e.inval) begin
                    report("invalidate", 64'(o_invalidate), 64'(e.inval));
                end
                if (o_status !== e.status) begin
                    report("status", 64'(o_status), 64'(e.status));
                end
            end
            n_done <= n_done + 1;
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        if ((start && !busy) || o_valid) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    initial begin
        int sel;
        i_rst_n = 1'b0;
        pause_next = 1'b0;

        // directed
        add_alloc({52{1'b1}}, 1'b1, 1'b1, 1'b0);
        add_alloc('0, 1'b0, 1'b0, 1'b1);
        add_alloc(52'h0_0000_0000_0fff, 1'b1, 1'b0, 1'b1);
        add_alloc(52'hf_ffff_ffff_f000, 1'b0, 1'b1, 1'b0);
        add_release(WIN_BASE | 64'hfff);
        add_alloc(52'h5_5555_5555_5555, 1'b1, 1'b1, 1'b1);
        add_release(WIN_BASE | (64'd1 << 12));
        add_release(WIN_BASE | (64'd1 << 12) | 64'h800);
        add_release(WIN_BASE - 64'd1);
        add_release('0);
        add_release(64'h7fff_ffff_ffff_ffff);
        add_release({64{1'b1}});
        add_release(WIN_BASE | (64'(RESERVED) << 12));
        add_release(WIN_BASE | (64'(RESERVED - 1) << 12));
        add_alloc(52'ha_aaaa_aaaa_aaaa, 1'b0, 1'b0, 1'b0);
        add_alloc(52'h0_0000_0000_1000, 1'b1, 1'b1, 1'b0);
        add_release(WIN_BASE | (64'd3 << 12));
        add_alloc(52'h8_0000_0000_0000, 1'b0, 1'b1, 1'b1);
        add_alloc(52'h0_0000_0000_0001, 1'b1, 1'b0, 1'b0);

        // fill the window past full
        pause_next = 1'b1;
        for (int i = 0; i < 520; i++) begin
            add_random_alloc();
        end

        // mixed traffic near full
        for (int i = 0; i < 200; i++) begin
            sel = $urandom_range(0, 99);
            if (sel < 45) begin
                add_random_alloc();
            end else if (sel < 85) begin
                add_release(slot_addr($urandom_range(0, RESERVED - 1)));
            end else begin
                add_noise();
            end
        end

        // release-heavy traffic
        pause_next = 1'b1;
        for (int i = 0; i < 130; i++) begin
            sel = $urandom_range(0, 99);
            if (sel < 25) begin
                add_random_alloc();
            end else if (sel < 90) begin
                add_release(slot_addr($urandom_range(0, RESERVED - 1)));
            end else begin
                add_noise();
            end
        end

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        while (pending_q.size() > 0 || start || expected_q.size() > 0) begin
            @(posedge i_clk);
        end
        repeat (8) @(posedge i_clk);
        if (n_err == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
